// ===== rtl/seg_map_pkg.sv =====
package seg_map_pkg;

    typedef struct packed {
        logic mir;
        logic deg;
        logic neg_c;
        logic neg_s;
    } t_flags;

endpackage

// ===== rtl/seg_map_prep.sv =====
module seg_map_prep #(
    parameter int C    = 16,
    parameter int F    = 16,
    parameter int DENW = 33,
    parameter int NW   = 49
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [C-1:0]    i_src_start_x,
    input  logic signed [C-1:0]    i_src_start_y,
    input  logic signed [C-1:0]    i_src_end_x,
    input  logic signed [C-1:0]    i_src_end_y,
    input  logic signed [C-1:0]    i_dst_start_x,
    input  logic signed [C-1:0]    i_dst_start_y,
    input  logic signed [C-1:0]    i_dst_end_x,
    input  logic signed [C-1:0]    i_dst_end_y,
    input  logic                   i_mirrored,
    output logic                   o_valid,
    output logic [DENW-1:0]        o_den,
    output logic [NW-1:0]          o_num_c,
    output logic [NW-1:0]          o_num_s,
    output seg_map_pkg::t_flags    o_flags,
    output logic [4*C-1:0]         o_co
);

    localparam int PW = 2 * C + 2;

    logic [2:0]              r_v;
    logic signed [C:0]       r1_ux, r1_uy, r1_vx, r1_vy;
    logic                    r1_mir, r2_mir;
    logic [4*C-1:0]          r1_co, r2_co, r3_co;
    logic signed [PW-1:0]    r2_uxx, r2_uyy, r2_vxux, r2_vyuy, r2_uxvy, r2_uyvx;
    logic signed [PW-1:0]    n_den, n_pc, n_ps, n_mag_c, n_mag_s;
    logic [DENW-1:0]         r3_den;
    logic [NW-1:0]           r3_num_c, r3_num_s;
    seg_map_pkg::t_flags     r3_flags, n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ux  <= $signed({i_src_end_x[C-1], i_src_end_x})
                    - $signed({i_src_start_x[C-1], i_src_start_x});
            r1_uy  <= $signed({i_src_end_y[C-1], i_src_end_y})
                    - $signed({i_src_start_y[C-1], i_src_start_y});
            r1_vx  <= $signed({i_dst_end_x[C-1], i_dst_end_x})
                    - $signed({i_dst_start_x[C-1], i_dst_start_x});
            r1_vy  <= $signed({i_dst_end_y[C-1], i_dst_end_y})
                    - $signed({i_dst_start_y[C-1], i_dst_start_y});
            r1_mir <= i_mirrored;
            r1_co  <= {i_src_start_x, i_src_start_y, i_dst_start_x, i_dst_start_y};

            r2_uxx  <= r1_ux * r1_ux;
            r2_uyy  <= r1_uy * r1_uy;
            r2_vxux <= r1_vx * r1_ux;
            r2_vyuy <= r1_vy * r1_uy;
            r2_uxvy <= r1_ux * r1_vy;
            r2_uyvx <= r1_uy * r1_vx;
            r2_mir  <= r1_mir;
            r2_co   <= r1_co;

            r3_den   <= n_den[DENW-1:0];
            r3_num_c <= {n_mag_c[DENW-1:0], {F{1'b0}}};
            r3_num_s <= {n_mag_s[DENW-1:0], {F{1'b0}}};
            r3_flags <= n_flags;
            r3_co    <= r2_co;
        end
    end

    always_comb begin
        n_den = r2_uxx + r2_uyy;
        if (r2_mir) begin
            n_pc = r2_vxux - r2_vyuy;
            n_ps = r2_uyvx + r2_uxvy;
        end else begin
            n_pc = r2_vxux + r2_vyuy;
            n_ps = r2_uxvy - r2_uyvx;
        end
        n_mag_c       = n_pc[PW-1] ? -n_pc : n_pc;
        n_mag_s       = n_ps[PW-1] ? -n_ps : n_ps;
        n_flags.mir   = r2_mir;
        n_flags.deg   = (n_den == '0);
        n_flags.neg_c = n_pc[PW-1];
        n_flags.neg_s = n_ps[PW-1];
    end

    assign o_valid = r_v[2];
    assign o_den   = r3_den;
    assign o_num_c = r3_num_c;
    assign o_num_s = r3_num_s;
    assign o_flags = r3_flags;
    assign o_co    = r3_co;

endmodule

// ===== rtl/seg_map_div.sv =====
module seg_map_div #(
    parameter int DENW = 33,
    parameter int NW   = 49,
    parameter int QB   = 33,
    parameter int SW   = 68
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DENW-1:0]   i_den,
    input  logic [NW-1:0]     i_num_c,
    input  logic [NW-1:0]     i_num_s,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [QB-1:0]     o_q_c,
    output logic [QB-1:0]     o_q_s,
    output logic              o_nz_c,
    output logic              o_nz_s,
    output logic [SW-1:0]     o_side
);

    logic                cur_v     [QB+1];
    logic [DENW-1:0]     cur_den   [QB+1];
    logic [DENW-1:0]     cur_rem_c [QB+1];
    logic [DENW-1:0]     cur_rem_s [QB+1];
    logic [QB-1:0]       cur_nq_c  [QB+1];
    logic [QB-1:0]       cur_nq_s  [QB+1];
    logic [SW-1:0]       cur_side  [QB+1];

    assign cur_v[0]     = i_valid;
    assign cur_den[0]   = i_den;
    assign cur_rem_c[0] = {{(DENW-NW+QB){1'b0}}, i_num_c[NW-1:QB]};
    assign cur_rem_s[0] = {{(DENW-NW+QB){1'b0}}, i_num_s[NW-1:QB]};
    assign cur_nq_c[0]  = i_num_c[QB-1:0];
    assign cur_nq_s[0]  = i_num_s[QB-1:0];
    assign cur_side[0]  = i_side;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [DENW:0]   t_c, t_s, d_c, d_s;
        logic            ge_c, ge_s;
        logic            r_v;
        logic [DENW-1:0] r_den, r_rem_c, r_rem_s;
        logic [QB-1:0]   r_nq_c, r_nq_s;
        logic [SW-1:0]   r_side;

        assign t_c  = {cur_rem_c[k], cur_nq_c[k][QB-1]};
        assign t_s  = {cur_rem_s[k], cur_nq_s[k][QB-1]};
        assign d_c  = t_c - {1'b0, cur_den[k]};
        assign d_s  = t_s - {1'b0, cur_den[k]};
        assign ge_c = (t_c >= {1'b0, cur_den[k]});
        assign ge_s = (t_s >= {1'b0, cur_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= cur_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den   <= cur_den[k];
                r_rem_c <= ge_c ? d_c[DENW-1:0] : t_c[DENW-1:0];
                r_rem_s <= ge_s ? d_s[DENW-1:0] : t_s[DENW-1:0];
                r_nq_c  <= {cur_nq_c[k][QB-2:0], ge_c};
                r_nq_s  <= {cur_nq_s[k][QB-2:0], ge_s};
                r_side  <= cur_side[k];
            end
        end

        assign cur_v[k+1]     = r_v;
        assign cur_den[k+1]   = r_den;
        assign cur_rem_c[k+1] = r_rem_c;
        assign cur_rem_s[k+1] = r_rem_s;
        assign cur_nq_c[k+1]  = r_nq_c;
        assign cur_nq_s[k+1]  = r_nq_s;
        assign cur_side[k+1]  = r_side;
    end

    assign o_valid = cur_v[QB];
    assign o_q_c   = cur_nq_c[QB];
    assign o_q_s   = cur_nq_s[QB];
    assign o_nz_c  = |cur_rem_c[QB];
    assign o_nz_s  = |cur_rem_s[QB];
    assign o_side  = cur_side[QB];

endmodule

// ===== rtl/seg_map_xlat.sv =====
module seg_map_xlat #(
    parameter int C  = 16,
    parameter int F  = 16,
    parameter int QB = 33,
    parameter int CW = 34,
    parameter int TW = 50
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [QB-1:0]          i_q_c,
    input  logic [QB-1:0]          i_q_s,
    input  logic                   i_nz_c,
    input  logic                   i_nz_s,
    input  seg_map_pkg::t_flags    i_flags,
    input  logic [4*C-1:0]         i_co,
    output logic                   o_valid,
    output logic signed [CW-1:0]   o_m00,
    output logic signed [CW-1:0]   o_m01,
    output logic signed [CW-1:0]   o_m10,
    output logic signed [CW-1:0]   o_m11,
    output logic signed [TW-1:0]   o_tx,
    output logic signed [TW-1:0]   o_ty,
    output logic                   o_degenerate
);

    localparam logic [CW-1:0] ONE = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    logic [2:0]              r_v;
    logic signed [CW-1:0]    pos_c, neg_c, pos_s, neg_s;
    logic signed [CW-1:0]    fc, fcm, fs, fsm;
    logic signed [CW-1:0]    n_a, n_b, n_c, n_d;
    logic signed [CW-1:0]    ra_a, ra_b, ra_c, ra_d, rb_a, rb_b, rb_c, rb_d;
    logic [4*C-1:0]          ra_co;
    logic signed [C-1:0]     ra_sx, ra_sy, rb_dx, rb_dy;
    logic                    ra_deg, rb_deg;
    logic signed [TW-1:0]    rb_ax, rb_by, rb_cx, rb_dys;
    logic signed [TW-1:0]    dxs, dys;
    logic signed [CW-1:0]    r_m00, r_m01, r_m10, r_m11;
    logic signed [TW-1:0]    r_tx, r_ty;
    logic                    r_deg;

    assign pos_c = $signed({1'b0, i_q_c});
    assign pos_s = $signed({1'b0, i_q_s});
    assign neg_c = -pos_c - $signed({{(CW-1){1'b0}}, i_nz_c});
    assign neg_s = -pos_s - $signed({{(CW-1){1'b0}}, i_nz_s});
    assign fc    = i_flags.neg_c ? neg_c : pos_c;
    assign fcm   = i_flags.neg_c ? pos_c : neg_c;
    assign fs    = i_flags.neg_s ? neg_s : pos_s;
    assign fsm   = i_flags.neg_s ? pos_s : neg_s;

    always_comb begin
        if (i_flags.deg) begin
            n_a = ONE;
            n_b = '0;
            n_c = '0;
            n_d = ONE;
        end else if (i_flags.mir) begin
            n_a = fc;
            n_b = fs;
            n_c = fs;
            n_d = fcm;
        end else begin
            n_a = fc;
            n_b = fsm;
            n_c = fs;
            n_d = fc;
        end
    end

    assign ra_sx = ra_co[4*C-1:3*C];
    assign ra_sy = ra_co[3*C-1:2*C];
    assign dxs   = {{(TW-C-F){rb_dx[C-1]}}, rb_dx, {F{1'b0}}};
    assign dys   = {{(TW-C-F){rb_dy[C-1]}}, rb_dy, {F{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_a   <= n_a;
            ra_b   <= n_b;
            ra_c   <= n_c;
            ra_d   <= n_d;
            ra_co  <= i_co;
            ra_deg <= i_flags.deg;

            rb_ax  <= ra_a * ra_sx;
            rb_by  <= ra_b * ra_sy;
            rb_cx  <= ra_c * ra_sx;
            rb_dys <= ra_d * ra_sy;
            rb_a   <= ra_a;
            rb_b   <= ra_b;
            rb_c   <= ra_c;
            rb_d   <= ra_d;
            rb_dx  <= ra_co[2*C-1:C];
            rb_dy  <= ra_co[C-1:0];
            rb_deg <= ra_deg;

            r_m00 <= rb_a;
            r_m01 <= rb_b;
            r_m10 <= rb_c;
            r_m11 <= rb_d;
            r_tx  <= rb_deg ? '0 : dxs - (rb_ax + rb_by);
            r_ty  <= rb_deg ? '0 : dys - (rb_cx + rb_dys);
            r_deg <= rb_deg;
        end
    end

    assign o_valid      = r_v[2];
    assign o_m00        = r_m00;
    assign o_m01        = r_m01;
    assign o_m10        = r_m10;
    assign o_m11        = r_m11;
    assign o_tx         = r_tx;
    assign o_ty         = r_ty;
    assign o_degenerate = r_deg;

endmodule

// ===== rtl/segment_mapping_transform_unit.sv =====
// Segment mapping transform: maps a source segment onto a destination segment.
// Input channel: i_valid with o_stall, eight signed endpoint coordinates and a
// mirror flag; a transaction completes when i_valid is high and o_stall low.
// Output channel: o_valid with i_stall, four Q.16 linear coefficients, the
// translation and the degenerate flag; a transaction completes when o_valid
// is high and i_stall low.
// The pipeline has three stages of differences, products and numerators, one
// stage per quotient bit in the restoring divider, then three stages of
// rounding, translation products and sums. One transaction is taken every
// cycle unless the output holds the pipeline.
// The whole pipeline advances together; it holds while a result waits at the
// output and i_stall is high, and o_stall follows at once.
// Reset empties the pipeline; no result is lost or repeated across a stall.
// A source of zero length yields the identity with o_degenerate set.
module segment_mapping_transform_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic signed [COORD_BITS-1:0]               i_src_start_x,
    input  logic signed [COORD_BITS-1:0]               i_src_start_y,
    input  logic signed [COORD_BITS-1:0]               i_src_end_x,
    input  logic signed [COORD_BITS-1:0]               i_src_end_y,
    input  logic signed [COORD_BITS-1:0]               i_dst_start_x,
    input  logic signed [COORD_BITS-1:0]               i_dst_start_y,
    input  logic signed [COORD_BITS-1:0]               i_dst_end_x,
    input  logic signed [COORD_BITS-1:0]               i_dst_end_y,
    input  logic                                       i_mirrored,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]     o_m00,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]     o_m01,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]     o_m10,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]     o_m11,
    output logic signed [2*COORD_BITS+FRAC_BITS+1:0]   o_tx,
    output logic signed [2*COORD_BITS+FRAC_BITS+1:0]   o_ty,
    output logic                                       o_degenerate
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DENW = 2 * C + 1;
    localparam int NW   = DENW + F;
    localparam int QB   = C + F + 1;
    localparam int CW   = QB + 1;
    localparam int TW   = 2 * C + F + 2;
    localparam int FLW  = $bits(seg_map_pkg::t_flags);
    localparam int SW   = 4 * C + FLW;

    logic                  en;
    logic                  p_valid, d_valid;
    logic [DENW-1:0]       p_den;
    logic [NW-1:0]         p_num_c, p_num_s;
    seg_map_pkg::t_flags   p_flags, d_flags;
    logic [4*C-1:0]        p_co;
    logic [SW-1:0]         d_side;
    logic [QB-1:0]         d_q_c, d_q_s;
    logic                  d_nz_c, d_nz_s;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;
    assign d_flags = d_side[FLW-1:0];

    seg_map_prep #(.C(C), .F(F), .DENW(DENW), .NW(NW)) u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_src_start_x (i_src_start_x),
        .i_src_start_y (i_src_start_y),
        .i_src_end_x   (i_src_end_x),
        .i_src_end_y   (i_src_end_y),
        .i_dst_start_x (i_dst_start_x),
        .i_dst_start_y (i_dst_start_y),
        .i_dst_end_x   (i_dst_end_x),
        .i_dst_end_y   (i_dst_end_y),
        .i_mirrored    (i_mirrored),
        .o_valid       (p_valid),
        .o_den         (p_den),
        .o_num_c       (p_num_c),
        .o_num_s       (p_num_s),
        .o_flags       (p_flags),
        .o_co          (p_co)
    );

    seg_map_div #(.DENW(DENW), .NW(NW), .QB(QB), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_den   (p_den),
        .i_num_c (p_num_c),
        .i_num_s (p_num_s),
        .i_side  ({p_co, p_flags}),
        .o_valid (d_valid),
        .o_q_c   (d_q_c),
        .o_q_s   (d_q_s),
        .o_nz_c  (d_nz_c),
        .o_nz_s  (d_nz_s),
        .o_side  (d_side)
    );

    seg_map_xlat #(.C(C), .F(F), .QB(QB), .CW(CW), .TW(TW)) u_xlat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (d_valid),
        .i_q_c        (d_q_c),
        .i_q_s        (d_q_s),
        .i_nz_c       (d_nz_c),
        .i_nz_s       (d_nz_s),
        .i_flags      (d_flags),
        .i_co         (d_side[SW-1:FLW]),
        .o_valid      (o_valid),
        .o_m00        (o_m00),
        .o_m01        (o_m01),
        .o_m10        (o_m10),
        .o_m11        (o_m11),
        .o_tx         (o_tx),
        .o_ty         (o_ty),
        .o_degenerate (o_degenerate)
    );

`ifndef SYNTHESIS
    a_deg_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_m01 == '0 && o_m10 == '0 && o_tx == '0
            && o_ty == '0 && o_m00 == o_m11)
        else $error("degenerate result is not the identity");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output hold");
`endif

endmodule

// ===== tb/segment_map_checker.sv =====
module segment_map_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [15:0] i_src_start_x,
    input  logic signed [15:0] i_src_start_y,
    input  logic signed [15:0] i_src_end_x,
    input  logic signed [15:0] i_src_end_y,
    input  logic signed [15:0] i_dst_start_x,
    input  logic signed [15:0] i_dst_start_y,
    input  logic signed [15:0] i_dst_end_x,
    input  logic signed [15:0] i_dst_end_y,
    input  logic               i_mirrored,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [33:0] o_m00,
    input  logic signed [33:0] o_m01,
    input  logic signed [33:0] o_m10,
    input  logic signed [33:0] o_m11,
    input  logic signed [49:0] o_tx,
    input  logic signed [49:0] o_ty,
    input  logic               o_degenerate,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;

    typedef struct {
        logic signed [33:0] m00;
        logic signed [33:0] m01;
        logic signed [33:0] m10;
        logic signed [33:0] m11;
        logic signed [49:0] tx;
        logic signed [49:0] ty;
        logic               degenerate;
    } t_transform;

    t_transform expected_maps[$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_maps.size();

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0))) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic t_transform map_segments(
        longint sx, longint sy, longint ex, longint ey,
        longint dx, longint dy, longint fx, longint fy, logic mir);
        t_transform t;
        longint one;
        longint ux, uy, vx, vy, den, pc, ps;
        longint a, b, c, d;
        one = longint'(1) << FRAC_BITS;
        ux  = ex - sx;
        uy  = ey - sy;
        vx  = fx - dx;
        vy  = fy - dy;
        den = ux * ux + uy * uy;
        if (den == 0) begin
            t.m00 = 34'(one);
            t.m01 = '0;
            t.m10 = '0;
            t.m11 = 34'(one);
            t.tx = '0;
            t.ty = '0;
            t.degenerate = 1'b1;
            return t;
        end
        if (!mir) begin
            pc = vx * ux + vy * uy;
            ps = ux * vy - uy * vx;
            a = floor_quot(pc * one, den);
            c = floor_quot(ps * one, den);
            b = floor_quot(-ps * one, den);
            d = a;
        end else begin
            pc = vx * ux - vy * uy;
            ps = vx * uy + vy * ux;
            a = floor_quot(pc * one, den);
            d = floor_quot(-pc * one, den);
            b = floor_quot(ps * one, den);
            c = b;
        end
        t.m00 = 34'(a);
        t.m01 = 34'(b);
        t.m10 = 34'(c);
        t.m11 = 34'(d);
        t.tx = 50'(dx * one - (a * sx + b * sy));
        t.ty = 50'(dy * one - (c * sx + d * sy));
        t.degenerate = 1'b0;
        return t;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_transform want;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_maps.push_back(map_segments(
                longint'(i_src_start_x), longint'(i_src_start_y),
                longint'(i_src_end_x), longint'(i_src_end_y),
                longint'(i_dst_start_x), longint'(i_dst_start_y),
                longint'(i_dst_end_x), longint'(i_dst_end_y), i_mirrored));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_maps.size() == 0) begin
                report("unexpected transaction", 0, 0);
            end else begin
                want = expected_maps.pop_front();
                if (o_m00 !== want.m00)
                    report("m00", longint'(o_m00), longint'(want.m00));
                if (o_m01 !== want.m01)
                    report("m01", longint'(o_m01), longint'(want.m01));
                if (o_m10 !== want.m10)
                    report("m10", longint'(o_m10), longint'(want.m10));
                if (o_m11 !== want.m11)
                    report("m11", longint'(o_m11), longint'(want.m11));
                if (o_tx !== want.tx)
                    report("tx", longint'(o_tx), longint'(want.tx));
                if (o_ty !== want.ty)
                    report("ty", longint'(o_ty), longint'(want.ty));
                if (o_degenerate !== want.degenerate)
                    report("degenerate", longint'(o_degenerate),
                           longint'(want.degenerate));
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 39;
    localparam int WATCH_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_src_start_x = '0;
    logic signed [15:0] i_src_start_y = '0;
    logic signed [15:0] i_src_end_x = '0;
    logic signed [15:0] i_src_end_y = '0;
    logic signed [15:0] i_dst_start_x = '0;
    logic signed [15:0] i_dst_start_y = '0;
    logic signed [15:0] i_dst_end_x = '0;
    logic signed [15:0] i_dst_end_y = '0;
    logic               i_mirrored = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [33:0] o_m00, o_m01, o_m10, o_m11;
    logic signed [49:0] o_tx, o_ty;
    logic               o_degenerate;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_taken = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    segment_mapping_transform_unit DUT (.*);

    segment_map_checker checker_inst (.*, .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        if (i_valid && !o_stall) items_taken++;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!hold_done && items_taken >= 100) begin
            hold_done = 1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_segments(
        input logic signed [15:0] sx, sy, ex, ey, dx, dy, fx, fy, input logic mir);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_src_start_x <= sx;
        i_src_start_y <= sy;
        i_src_end_x <= ex;
        i_src_end_y <= ey;
        i_dst_start_x <= dx;
        i_dst_start_y <= dy;
        i_dst_end_x <= fx;
        i_dst_end_y <= fy;
        i_mirrored <= mir;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_coord(int kind);
        case (kind)
            0: begin
                return 16'($urandom);
            end
            1: begin
                return 16'($urandom_range(0, 64)) - 16'sd32;
            end
            default: begin
                case ($urandom_range(4))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic send_random;
        logic signed [15:0] c[8];
        int kind;
        kind = $urandom_range(9);
        kind = (kind < 6) ? 0 : (kind < 9) ? 1 : 2;
        for (int k = 0; k < 8; k++) begin
            c[k] = pick_coord(kind);
        end
        if ($urandom_range(99) < 8) begin
            c[2] = c[0];
            c[3] = c[1];
        end else if ($urandom_range(99) < 10) begin
            c[3] = c[1];
        end
        send_segments(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], 1'($urandom));
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int m = 0; m < 2; m++) begin
            send_segments(5, -7, 5, -7, 100, 200, -300, 400, m);
            send_segments(-32768, -32768, -32768, -32768, 32767, 32767, 0, 0, m);
            send_segments(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768, m);
            send_segments(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767, m);
            send_segments(-32768, 32767, 32767, -32768, 32767, -32768, -32768, 32767, m);
            send_segments(0, 0, 1, 0, -32768, 32767, -32768, 32767, m);
            send_segments(0, 0, 1, 0, 0, 0, 0, 1, m);
            send_segments(0, 0, 0, 1, 0, 0, 3, 4, m);
            send_segments(-1, -1, 1, 2, 7, -3, -9, 11, m);
            send_segments(32767, -32768, -32768, 32767, 0, 0, 32767, -32768, m);
            send_segments(0, 0, 3, 0, 0, 0, 1, 0, m);
        end

        send_idle_pct = 11;
        recv_stall_pct = 45;
        repeat (400) send_random();
        send_idle_pct = 45;
        recv_stall_pct = 11;
        repeat (400) send_random();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (400) send_random();
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/seg_map_pkg.sv
rtl/seg_map_prep.sv
rtl/seg_map_div.sv
rtl/seg_map_xlat.sv
rtl/segment_mapping_transform_unit.sv
tb/segment_map_checker.sv
tb/testbench.sv
